[rtl/sdtq_pkg.sv]
// Package for the sorted deadline timer queue: beat payload structs, operation
// and status codes, and the command/status structs between controller and datapath.
// No dependencies.
package sdtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 32;
  localparam int ID_W            = 4;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] timer_id;
    logic [31:0]     timer_length;
  } sdtq_in_t;

  typedef struct packed {
    logic            expired;
    logic [ID_W-1:0] expired_id;
    logic [1:0]      status;
    logic [31:0]     current_time;
  } sdtq_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic grow_init;
    logic grow;
    logic place;
    logic commit;
  } sdtq_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic grow_done;
    logic add_go;
    logic out_free;
  } sdtq_sts_t;

endpackage

[rtl/sdtq_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module sdtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sdtq_ctrl.sv]
// Controller state machine for the sorted deadline timer queue.
// Depends on sdtq_pkg for the command and status structs.
module sdtq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output sdtq_pkg::sdtq_cmd_t cmd,
  input  sdtq_pkg::sdtq_sts_t sts
);
  import sdtq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GROW,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          state_nxt    = S_SCAN;
          in_ready_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.add_go) begin
            cmd.grow_init = 1'b1;
            state_nxt     = S_GROW;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_GROW: begin
        cmd.grow = 1'b1;
        if (sts.grow_done) begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit   = 1'b1;
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

endmodule

[rtl/sdtq_dp.sv]
// Datapath of the sorted deadline timer queue: timestamp, entry count, entry
// memory with its sweep pointer, scan flags and the result register.
// Depends on sdtq_pkg and sdtq_ram.
module sdtq_dp #(
  parameter int QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_WIDTH  = sdtq_pkg::TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdtq_pkg::sdtq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdtq_pkg::sdtq_out_t out_data,
  input  sdtq_pkg::sdtq_cmd_t cmd,
  output sdtq_pkg::sdtq_sts_t sts
);
  import sdtq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = TIME_WIDTH + ID_W;

  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [TIME_WIDTH-1:0] dl_r, dl_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  rv_r, rv_nxt;
  logic [AW-1:0]         ra_r, ra_nxt;
  logic                  hit_r, hit_nxt;
  logic [ID_W-1:0]       hit_id_r, hit_id_nxt;
  logic                  dup_r, dup_nxt;
  logic                  pos_set_r, pos_set_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sdtq_out_t             out_r, out_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [RW-1:0]         ram_wdata, rd_data;
  logic [TIME_WIDTH-1:0] rd_dl;
  logic [ID_W-1:0]       rd_id;
  logic [CW-1:0]         idx_m1;
  logic                  full;
  logic [63:0]           now_ext;

  sdtq_ram #(
    .WIDTH(RW),
    .DEPTH(QUEUE_DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign rd_dl   = rd_data[RW-1:ID_W];
  assign rd_id   = rd_data[ID_W-1:0];
  assign idx_m1  = idx_r - 1'b1;
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign now_ext = 64'(now_r);

  assign sts.scan_done = (idx_r >= count_r) && !rv_r;
  assign sts.grow_done = (idx_r <= pos_r) && !rv_r;
  assign sts.add_go    = (op_r == OP_ADD) && !dup_r && !full;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    now_nxt       = now_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    dl_nxt        = dl_r;
    idx_nxt       = idx_r;
    rv_nxt        = rv_r;
    ra_nxt        = ra_r;
    hit_nxt       = hit_r;
    hit_id_nxt    = hit_id_r;
    dup_nxt       = dup_r;
    pos_set_nxt   = pos_set_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = rd_data;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    if (cmd.load) begin
      op_nxt      = in_data.operation;
      id_nxt      = in_data.timer_id;
      dl_nxt      = now_r + TIME_WIDTH'(in_data.timer_length);
      if (in_data.operation == OP_TICK) begin
        now_nxt = now_r + 1'b1;
      end
      hit_nxt     = 1'b0;
      dup_nxt     = 1'b0;
      pos_set_nxt = 1'b0;
      idx_nxt     = '0;
      rv_nxt      = 1'b0;
    end

    // Forward sweep: read every live slot once. Tick and remove close the gap
    // behind the popped entry by writing each later slot one place lower.
    if (cmd.scan) begin
      if (idx_r < count_r) begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[AW-1:0];
        idx_nxt   = idx_r + 1'b1;
        rv_nxt    = 1'b1;
        ra_nxt    = idx_r[AW-1:0];
      end else begin
        rv_nxt = 1'b0;
      end
      if (rv_r) begin
        case (op_r)
          OP_TICK: begin
            if (hit_r) begin
              ram_we    = 1'b1;
              ram_waddr = ra_r - 1'b1;
            end else if (ra_r == '0 && rd_dl <= now_r) begin
              hit_nxt    = 1'b1;
              hit_id_nxt = rd_id;
            end
          end
          OP_REMOVE: begin
            if (hit_r) begin
              ram_we    = 1'b1;
              ram_waddr = ra_r - 1'b1;
            end else if (rd_id == id_r) begin
              hit_nxt = 1'b1;
            end
          end
          OP_ADD: begin
            if (rd_id == id_r) begin
              dup_nxt = 1'b1;
            end
            if (!pos_set_r && rd_dl > dl_r) begin
              pos_set_nxt = 1'b1;
              pos_nxt     = CW'(ra_r);
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd.grow_init) begin
      idx_nxt = count_r;
      rv_nxt  = 1'b0;
      if (!pos_set_r) begin
        pos_nxt = count_r;
      end
    end

    // Backward sweep: move the slots from the tail down to the insertion
    // point one place higher, opening a hole at the insertion point.
    if (cmd.grow) begin
      if (idx_r > pos_r) begin
        ram_re    = 1'b1;
        ram_raddr = idx_m1[AW-1:0];
        idx_nxt   = idx_m1;
        rv_nxt    = 1'b1;
        ra_nxt    = idx_m1[AW-1:0];
      end else begin
        rv_nxt = 1'b0;
      end
      if (rv_r) begin
        ram_we    = 1'b1;
        ram_waddr = ra_r + 1'b1;
      end
    end

    if (cmd.place) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r[AW-1:0];
      ram_wdata = {dl_r, id_r};
    end

    if (cmd.commit) begin
      out_valid_nxt        = 1'b1;
      out_nxt.expired      = (op_r == OP_TICK) && hit_r;
      out_nxt.expired_id   = ((op_r == OP_TICK) && hit_r) ? hit_id_r : '0;
      out_nxt.current_time = now_ext[31:0];
      case (op_r)
        OP_ADD: begin
          if (dup_r) begin
            out_nxt.status = ST_DUP;
          end else if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            out_nxt.status = ST_OK;
            count_nxt      = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (hit_r) begin
            out_nxt.status = ST_OK;
            count_nxt      = count_r - 1'b1;
          end else begin
            out_nxt.status = ST_ABSENT;
          end
        end
        OP_TICK: begin
          out_nxt.status = ST_OK;
          if (hit_r) begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          out_nxt.status = ST_OK;
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      count_r     <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      now_r       <= now_nxt;
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    dl_r      <= dl_nxt;
    idx_r     <= idx_nxt;
    ra_r      <= ra_nxt;
    hit_r     <= hit_nxt;
    hit_id_r  <= hit_id_nxt;
    dup_r     <= dup_nxt;
    pos_set_r <= pos_set_nxt;
    pos_r     <= pos_nxt;
    out_r     <= out_nxt;
  end

endmodule

[rtl/sorted_deadline_timer_queue.sv]
// Top level of the sorted deadline timer queue.
// Depends on sdtq_pkg, sdtq_ctrl, sdtq_dp and sdtq_ram.
//
// The block keeps a millisecond timestamp and up to QUEUE_DEPTH timer ids in
// a memory, ordered by deadline. Each input beat is a tick, an add or a
// remove, and each one yields exactly one result beat carrying the expiry
// flag and id, a status code and the timestamp after the operation. A tick
// pops at most one expired timer. Deadlines wrap modulo 2^TIME_WIDTH and are
// compared as plain unsigned values, so a deadline past the wrap point
// counts as early. All work goes through a sweep of the entry memory, which
// has one write port and one registered read port, one slot per cycle.
// Every beat runs a forward sweep over the queued entries; a successful add
// then runs a backward sweep over the entries that move up to make room,
// followed by the insertion write. An unused operation code only sweeps
// and reports ST_OK. A new beat is accepted once the previous one has been
// processed, even while its result still waits in the output register; the
// next result is only written once that one has been taken, and until then
// the block holds off its input. The entry memory needs no clearing after
// reset, since only slots below the entry count are ever read.
module sorted_deadline_timer_queue #(
  parameter int QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_WIDTH  = sdtq_pkg::TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdtq_pkg::sdtq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdtq_pkg::sdtq_out_t out_data
);
  import sdtq_pkg::*;

  // Commands from the controller and status back from the datapath.
  sdtq_cmd_t cmd;
  sdtq_sts_t sts;

  // The controller sequences each beat: accept, forward sweep, optional
  // backward sweep with the insertion write, then the result commit.
  sdtq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  // The datapath holds the timestamp, the entry memory and the result register.
  sdtq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
